/* src/cansigx_pkg.sv */
// Shared types and constants for the CAN signal extractor.
package cansigx_pkg;

    localparam int NUM_SIGNALS    = 16;
    localparam int MAX_FIELD_BITS = 32;
    localparam int INDEX_SPAN     = 16;
    localparam int TBL_DEPTH      = (NUM_SIGNALS < INDEX_SPAN) ? NUM_SIGNALS : INDEX_SPAN;
    localparam int TBL_IDX_W      = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

    localparam int ID_W      = 11;
    localparam int START_W   = 6;
    localparam int LEN_W     = 6;
    localparam int INDEX_W   = 4;
    localparam int PAYLOAD_W = 64;
    localparam int VALUE_W   = 32;

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 40;

    typedef enum logic {
        OP_TABLE_WRITE = 1'b0,
        OP_FRAME       = 1'b1
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
    } entry_t;

endpackage

/* src/can_signal_extractor.sv */
// Table-driven CAN signal extractor: signal table, scan sequencer and field extraction unit.
//
// A table write produces nothing. A frame is taken, then the sequencer walks the table
// one entry per cycle while the output is not stalled, through a single extraction
// unit, up to the last matching entry. One request is emitted per matching entry, in
// index order, with tlast on the final one. The input is not ready during the walk; a
// frame that matches nothing leaves the block ready on the next cycle.
module can_signal_extractor
    import cansigx_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // table_index[3:0], entry_id[14:4], entry_start_bit[20:15], entry_length[26:21],
    // frame_id[37:27], frame_payload[101:38], zero fill
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // signal_index[3:0], signal_value[35:4], zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // malformed
    output logic                  m_axis_tuser,
    output logic                  m_axis_tlast
);

    state_t                  state_reg, state_next;
    logic [TBL_IDX_W-1:0]    idx_reg, idx_next;
    logic [TBL_DEPTH-1:0]    match_reg, match_next;
    logic [PAYLOAD_W-1:0]    payload_reg;
    entry_t                  tbl_reg [TBL_DEPTH];

    logic                    out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]      out_index_reg;
    logic [VALUE_W-1:0]      out_value_reg;
    logic                    out_bad_reg;
    logic                    out_last_reg;

    logic [INDEX_W-1:0]      in_table_index;
    entry_t                  in_entry;
    logic [ID_W-1:0]         in_frame_id;
    logic [PAYLOAD_W-1:0]    in_payload;
    logic                    in_accept;
    logic                    in_is_frame;
    logic [TBL_DEPTH-1:0]    match_vec;

    entry_t                  cur;
    logic [2:0]              byte_pos;
    logic [2:0]              bit_ofs;
    logic [LEN_W-1:0]        len;
    logic [PAYLOAD_W-1:0]    win;
    logic [7:0]              b0, b1, b2, b3;
    logic [3:0]              nbytes;
    logic [3:0]              rbits;
    logic [7:0]              last_byte;
    logic [23:0]             whole;
    logic [7:0]              part_mask;
    logic [7:0]              part;
    logic                    bad;
    logic [VALUE_W-1:0]      value;
    logic [TBL_DEPTH-1:0]    rest;
    logic                    out_free;
    logic                    load_out;

    assign in_table_index = s_axis_tdata[3:0];
    assign in_entry.id     = s_axis_tdata[14:4];
    assign in_entry.start  = s_axis_tdata[20:15];
    assign in_entry.length = s_axis_tdata[26:21];
    assign in_frame_id    = s_axis_tdata[37:27];
    assign in_payload     = s_axis_tdata[101:38];

    assign in_accept   = s_axis_tvalid && s_axis_tready;
    assign in_is_frame = (op_t'(s_axis_tuser) == OP_FRAME);

    always_comb
    begin
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            match_vec[i] = (tbl_reg[i].id == in_frame_id);
        end
    end

    // Extraction unit, one table entry per cycle unless the output stalls
    always_comb
    begin
        cur       = tbl_reg[idx_reg];
        byte_pos  = cur.start[5:3];
        bit_ofs   = cur.start[2:0];
        len       = cur.length;
        win       = payload_reg >> {byte_pos, 3'b000};
        b0        = win[7:0];
        b1        = win[15:8];
        b2        = win[23:16];
        b3        = win[31:24];
        nbytes    = 4'((7'(len) + 7'd7) >> 3);
        rbits     = (len[2:0] == 3'd0) ? 4'd8 : {1'b0, len[2:0]};
        unique case (nbytes)
            4'd1:    last_byte = b0;
            4'd2:    last_byte = b1;
            4'd3:    last_byte = b2;
            4'd4:    last_byte = b3;
            default: last_byte = 8'd0;
        endcase
        unique case (nbytes)
            4'd2:    whole = {16'd0, b0};
            4'd3:    whole = {8'd0, b0, b1};
            4'd4:    whole = {b0, b1, b2};
            default: whole = 24'd0;
        endcase
        part_mask = 8'((9'd1 << rbits) - 9'd1);
        part      = (last_byte >> bit_ofs) & part_mask;
        bad       = (len > LEN_W'(MAX_FIELD_BITS))
                    || ((len != '0) && ((4'(bit_ofs) + rbits) > 4'd8));
        if (bad || (len == '0))
        begin
            value = '0;
        end
        else
        begin
            value = (VALUE_W'(whole) << rbits) | VALUE_W'(part);
        end
    end

    assign rest     = match_reg & ~(TBL_DEPTH'(1) << idx_reg);
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        match_next     = match_reg;
        s_axis_tready  = 1'b0;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && !m_axis_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (in_accept && in_is_frame && (match_vec != '0))
                begin
                    state_next = ST_SCAN;
                    idx_next   = '0;
                    match_next = match_vec;
                end
            end
            ST_SCAN:
            begin
                if (match_reg[idx_reg])
                begin
                    if (out_free)
                    begin
                        load_out       = 1'b1;
                        out_valid_next = 1'b1;
                        match_next     = rest;
                        if (rest == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            match_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            match_reg     <= match_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Signal table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TBL_DEPTH; i++)
            begin
                tbl_reg[i] <= '0;
            end
        end
        else if (in_accept && !in_is_frame && (int'(in_table_index) < TBL_DEPTH))
        begin
            tbl_reg[in_table_index[TBL_IDX_W-1:0]] <= in_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && in_is_frame)
        begin
            payload_reg <= in_payload;
        end
        if (load_out)
        begin
            out_index_reg <= INDEX_W'(idx_reg);
            out_value_reg <= value;
            out_bad_reg   <= bad;
            out_last_reg  <= (rest == '0);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_value_reg, out_index_reg};
    assign m_axis_tuser  = out_bad_reg;
    assign m_axis_tlast  = out_last_reg;

    a_scan_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (match_reg != '0))
        else $error("scan running with no pending match");

    a_malformed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[35:4] == '0))
        else $error("malformed result carries nonzero value");

    a_no_match_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_is_frame && (match_vec == '0)) |=> (state_reg == ST_IDLE))
        else $error("unmatched frame started a scan");

    a_last_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && (rest == '0) |=> (state_reg == ST_IDLE) && m_axis_tlast)
        else $error("final result did not end the scan");

endmodule

/* verif/can_signal_extractor_test.sv */
// Self-checking testbench for the CAN signal extractor: directed, random and backpressure tests.
module can_signal_extractor_test;
    import cansigx_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 100;

    typedef struct {
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
        logic               malformed;
        logic               last;
    } signal_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    entry_t         table_shadow [TBL_DEPTH];
    signal_result_t expected_signals [$];
    logic [ID_W-1:0] id_pool [4];

    int  errors;
    int  n_requests;
    int  n_frames;
    int  n_results;
    int  n_malformed;
    int  rx_hold;
    int  rx_gap;
    bit  tx_gaps_on;
    bit  rx_gaps_on;

    can_signal_extractor u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Big-endian field pull; returns the malformed flag.
    function automatic logic field_extract(input entry_t e, input logic [63:0] pl,
                                           output logic [VALUE_W-1:0] val);
        int unsigned        p;
        int unsigned        o;
        int unsigned        len;
        int unsigned        n;
        int unsigned        r;
        int unsigned        sh;
        int unsigned        k;
        logic [7:0]         b;
        logic [VALUE_W-1:0] part;
        logic [VALUE_W-1:0] acc;
        val = '0;
        p   = e.start / 8;
        o   = e.start % 8;
        len = e.length;
        n   = (len + 7) / 8;
        acc = '0;
        if (len > MAX_FIELD_BITS)
            return 1'b1;
        for (k = 0; k < n; k++)
        begin
            b = (p + k > 7) ? 8'h00 : 8'(pl >> (8 * (p + k)));
            if (k == n - 1)
            begin
                r = len - 8 * (n - 1);
                if (o + r > 8)
                    return 1'b1;
                part = 32'(b >> o) & ((32'd1 << r) - 32'd1);
            end
            else
                part = 32'(b);
            sh  = (len > 8 * (k + 1)) ? len - 8 * (k + 1) : 0;
            acc = acc + (part << sh);
        end
        val = acc;
        return 1'b0;
    endfunction

    function automatic void predict_frame(input logic [ID_W-1:0] fid, input logic [63:0] pl);
        signal_result_t hits [$];
        signal_result_t rec;
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            if (table_shadow[i].id == fid)
            begin
                rec.index     = INDEX_W'(i);
                rec.malformed = field_extract(table_shadow[i], pl, rec.value);
                rec.last      = 1'b0;
                hits.push_back(rec);
            end
        end
        if (hits.size() > 0)
            hits[hits.size() - 1].last = 1'b1;
        foreach (hits[j])
            expected_signals.push_back(hits[j]);
    endfunction

    // Called right after a falling edge; returns right after a falling edge, once the request has been taken.
    task automatic send_request(input op_t op, input logic [INDEX_W-1:0] idx,
                                input logic [ID_W-1:0] eid, input logic [START_W-1:0] est,
                                input logic [LEN_W-1:0] elen, input logic [ID_W-1:0] fid,
                                input logic [63:0] pl);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tuser  = op;
        s_axis_tdata  = IN_DATA_W'({pl, fid, elen, est, eid, idx});
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        n_requests++;
        if (op == OP_TABLE_WRITE)
        begin
            if (idx < TBL_DEPTH)
                table_shadow[idx] = '{id: eid, start: est, length: elen};
        end
        else
        begin
            n_frames++;
            predict_frame(fid, pl);
        end
        @(negedge clk);
    endtask

    task automatic write_entry(input logic [INDEX_W-1:0] idx, input logic [ID_W-1:0] eid,
                               input logic [START_W-1:0] est, input logic [LEN_W-1:0] elen);
        send_request(OP_TABLE_WRITE, idx, eid, est, elen, ID_W'($urandom), rand64());
    endtask

    task automatic send_frame(input logic [ID_W-1:0] fid, input logic [63:0] pl);
        send_request(OP_FRAME, INDEX_W'($urandom), ID_W'($urandom), START_W'($urandom),
                     LEN_W'($urandom), fid, pl);
    endtask

    // Sender pause: lets every expected result arrive and the walk finish.
    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (expected_signals.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic test_reset_table();
        send_frame('0, '1);
        send_frame(11'd5, rand64());
        wait_drained();
    endtask

    task automatic test_field_extremes();
        write_entry(4'd0,  11'h7FF, 6'd0,  6'd8);
        write_entry(4'd1,  11'h7FF, 6'd63, 6'd1);
        write_entry(4'd2,  11'h7FF, 6'd0,  6'd32);
        write_entry(4'd3,  11'h7FF, 6'd40, 6'd32);   // runs past byte 7
        write_entry(4'd4,  11'h7FF, 6'd60, 6'd32);   // last byte overrun
        write_entry(4'd5,  11'h7FF, 6'd3,  6'd5);
        write_entry(4'd6,  11'h7FF, 6'd4,  6'd5);    // last byte overrun
        write_entry(4'd7,  11'h7FF, 6'd8,  6'd33);   // overlong
        write_entry(4'd8,  11'h7FF, 6'd63, 6'd63);   // overlong
        write_entry(4'd9,  11'h7FF, 6'd17, 6'd0);    // zero length
        write_entry(4'd15, 11'h7FF, 6'd56, 6'd8);
        send_frame(11'h7FF, '1);
        send_frame(11'h7FF, '0);
        send_frame(11'h7FF, 64'h0123_4567_89AB_CDEF);
        send_frame(11'h7FF, rand64());
        send_frame('0, rand64());
        wait_drained();
    endtask

    task automatic random_entry();
        logic [INDEX_W-1:0] idx;
        logic [ID_W-1:0]    eid;
        logic [START_W-1:0] est;
        logic [LEN_W-1:0]   elen;
        int                 r;
        int                 rem;
        idx = INDEX_W'($urandom);
        eid = ($urandom_range(0, 4) != 0) ? id_pool[$urandom_range(0, 3)] : ID_W'($urandom);
        r   = $urandom_range(0, 99);
        if (r < 70)
            elen = LEN_W'($urandom_range(1, MAX_FIELD_BITS));
        else if (r < 85)
            elen = LEN_W'($urandom_range(0, 8));
        else
            elen = LEN_W'($urandom_range(MAX_FIELD_BITS + 1, 63));
        if ($urandom_range(0, 1) != 0 && elen != 0 && elen <= MAX_FIELD_BITS)
        begin
            // keep the last byte inside its eight bits
            rem = elen - 8 * ((elen + 7) / 8 - 1);
            est = START_W'(8 * $urandom_range(0, 7) + $urandom_range(0, 8 - rem));
        end
        else
            est = START_W'($urandom);
        write_entry(idx, eid, est, elen);
    endtask

    task automatic test_random_traffic();
        int r;
        for (int i = 0; i < 4; i++)
            id_pool[i] = ID_W'($urandom);
        for (int i = 0; i < 16; i++)
            random_entry();
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 32 == 0)
            begin
                tx_gaps_on = ($urandom_range(0, 3) != 0);
                rx_gaps_on = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 99) < 35)
                random_entry();
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    send_frame(table_shadow[$urandom_range(0, TBL_DEPTH - 1)].id, rand64());
                else if (r < 90)
                    send_frame(ID_W'($urandom), rand64());
                else
                    send_frame(id_pool[$urandom_range(0, 3)], rand64());
            end
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        wait_drained();
    endtask

    task automatic test_backpressure();
        logic [ID_W-1:0] fid;
        fid = ID_W'($urandom);
        for (int i = 0; i < TBL_DEPTH; i++)
            write_entry(INDEX_W'(i), fid, START_W'($urandom), LEN_W'($urandom_range(0, 40)));
        wait_drained();
        tx_gaps_on = 1'b0;
        @(posedge clk);
        rx_hold = HOLD_CYCLES;
        @(negedge clk);
        for (int i = 0; i < 12; i++)
            send_frame(fid, rand64());
        tx_gaps_on = 1'b1;
        wait_drained();
    endtask

    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_axis_tready = 1'b0;
            rx_hold       = rx_hold - 1;
        end
        else if (rx_gap > 0)
        begin
            m_axis_tready = 1'b0;
            rx_gap        = rx_gap - 1;
        end
        else
        begin
            m_axis_tready = 1'b1;
            if (rx_gaps_on)
                rx_gap = pick_gap();
        end
    end

    always @(posedge clk)
    begin : result_check
        signal_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_results++;
            if (m_axis_tuser)
                n_malformed++;
            if (expected_signals.size() == 0)
            begin
                $error("unexpected result: index %0d value %0h",
                       m_axis_tdata[3:0], m_axis_tdata[35:4]);
                errors++;
            end
            else
            begin
                want = expected_signals.pop_front();
                if (m_axis_tdata[3:0] !== want.index)
                begin
                    $error("signal_index: expected %0d, got %0d", want.index, m_axis_tdata[3:0]);
                    errors++;
                end
                if (m_axis_tdata[35:4] !== want.value)
                begin
                    $error("signal_value: expected %0h, got %0h", want.value, m_axis_tdata[35:4]);
                    errors++;
                end
                if (m_axis_tuser !== want.malformed)
                begin
                    $error("malformed: expected %0b, got %0b", want.malformed, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last_of_frame: expected %0b, got %0b", want.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
        end
        $error("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        errors        = 0;
        n_requests    = 0;
        n_frames      = 0;
        n_results     = 0;
        n_malformed   = 0;
        rx_hold       = 0;
        rx_gap        = 0;
        tx_gaps_on    = 1'b1;
        rx_gaps_on    = 1'b1;
        foreach (table_shadow[i])
            table_shadow[i] = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_reset_table();
        test_field_extremes();
        test_random_traffic();
        test_backpressure();

        if (expected_signals.size() != 0)
        begin
            $error("%0d results never arrived", expected_signals.size());
            errors++;
        end
        $display("Covered %0d requests (%0d frames), %0d signal results, %0d malformed.",
                 n_requests, n_frames, n_results, n_malformed);
        $display("Included reset-table hits, payload edge fields and a long output stall.");
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
